>>> rtl/ffha_pkg.sv
// Shared types, constants and helper functions for the first-fit heap allocator.
// No dependencies; every other file of the block imports this package.
package ffha_pkg;

   localparam int HEAP_BYTES    = 1024;
   localparam int GRANULE_BYTES = 16;
   localparam int NUM_GRANULES  = HEAP_BYTES / GRANULE_BYTES;
   localparam int GRAN_SHIFT    = $clog2(GRANULE_BYTES);
   localparam int GIDX_W        = $clog2(NUM_GRANULES);
   localparam int GLEN_W        = GIDX_W + 1;
   localparam int BYTES_W       = 16;
   localparam int OFFSET_W      = 10;
   localparam int SIZE_W        = 11;
   localparam int SCAN_LANES    = 4;
   localparam int SCAN_STEPS    = NUM_GRANULES / SCAN_LANES;
   localparam int STEP_W        = $clog2(SCAN_STEPS);
   localparam int LANE_W        = $clog2(SCAN_LANES);

   localparam logic MODE_ALLOC   = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   typedef logic [NUM_GRANULES-1:0] gmap_type;

   typedef struct packed {
      logic              hit;
      logic [GIDX_W-1:0] first;
      logic [GLEN_W-1:0] run;
   } scan_result_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_MARK = 5'b00100,
      ST_LEN  = 5'b01000,
      ST_PUSH = 5'b10000
   } state_type;

   // one bit per granule in [lo, lo+cnt)
   function automatic gmap_type range_mask(input logic [GIDX_W-1:0] lo,
                                           input logic [GLEN_W-1:0] cnt);
      gmap_type          m;
      logic [GLEN_W:0]   hi;
      logic [GLEN_W:0]   idx;
      hi = {2'b00, lo} + {1'b0, cnt};
      for (int i = 0; i < NUM_GRANULES; i++) begin
         idx  = (GLEN_W+1)'(i);
         m[i] = (idx >= {2'b00, lo}) && (idx < hi);
      end
      return m;
   endfunction

endpackage

>>> rtl/first_fit_heap_allocator_top.sv
// First-fit heap allocator over a 1024-byte heap of 16-byte granules. Each
// request item yields exactly one response item. An allocate scans the free
// map four granules per cycle with one shared scan unit, going from accept
// through up to 16 scan steps, the mark state and the push state to the
// response; a free passes through the length state, which uses the registered
// read of the length store issued at accept; rejected requests go straight to
// push. One request is in flight at a time; the response register lets the
// next request enter while a response waits to be taken.
// Depends on ffha_pkg, ffha_scan_unit and ffha_len_mem.
module first_fit_heap_allocator_top
   import ffha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] request_bytes, [25:16] release_offset, rest zero
   input  logic        req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [9:0] grant_offset, [20:10] grant_bytes, rest zero
   output logic        rsp_tuser    // [0] ok
);

   state_type          state_ff, state_in;
   gmap_type           free_ff, free_in;
   gmap_type           start_ff, start_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [GLEN_W-1:0]  run_ff, run_in;
   logic [GLEN_W-1:0]  need_ff, need_in;
   logic [GIDX_W-1:0]  gidx_ff, gidx_in;
   logic               res_ok_ff, res_ok_in;
   logic [OFFSET_W-1:0] res_offset_ff, res_offset_in;
   logic [SIZE_W-1:0]  res_bytes_ff, res_bytes_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_ok_ff;
   logic [OFFSET_W-1:0] rsp_offset_ff;
   logic [SIZE_W-1:0]  rsp_bytes_ff;

   logic [BYTES_W-1:0]  req_bytes;
   logic [OFFSET_W-1:0] req_offset;
   logic [BYTES_W:0]    bytes_round;
   logic [GIDX_W-1:0]   req_gidx;
   logic                req_fire;
   logic                rsp_load;

   scan_result_type     scan;
   logic [GIDX_W-1:0]   scan_base;
   logic [SCAN_LANES-1:0] scan_window;

   logic                mem_wr_en;
   logic                mem_rd_en;
   logic [GLEN_W-1:0]   mem_rd_data;

   assign req_bytes   = req_tdata[BYTES_W-1:0];
   assign req_offset  = req_tdata[BYTES_W +: OFFSET_W];
   assign bytes_round = {1'b0, req_bytes} + (BYTES_W+1)'(GRANULE_BYTES - 1);
   assign req_gidx    = req_offset[GRAN_SHIFT +: GIDX_W];
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;
   assign rsp_load    = (state_ff == ST_PUSH) && (!rsp_valid_ff || rsp_tready);

   assign scan_base   = {step_ff, LANE_W'(0)};
   assign scan_window = free_ff[scan_base +: SCAN_LANES];

   ffha_scan_unit u_scan (
      .run_count   (run_ff),
      .need        (need_ff),
      .base        (scan_base),
      .window_free (scan_window),
      .result      (scan)
   );

   assign mem_wr_en = (state_ff == ST_MARK);
   assign mem_rd_en = req_fire && (req_tuser == MODE_RELEASE);

   ffha_len_mem u_len_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (gidx_ff),
      .wr_data (need_ff),
      .rd_en   (mem_rd_en),
      .rd_addr (req_gidx),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      free_in       = free_ff;
      start_in      = start_ff;
      step_in       = step_ff;
      run_in        = run_ff;
      need_in       = need_ff;
      gidx_in       = gidx_ff;
      res_ok_in     = res_ok_ff;
      res_offset_in = res_offset_ff;
      res_bytes_in  = res_bytes_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_ok_in     = 1'b0;
               res_offset_in = '0;
               res_bytes_in  = '0;
               gidx_in       = req_gidx;
               step_in       = '0;
               run_in        = '0;
               need_in       = bytes_round[GRAN_SHIFT +: GLEN_W];
               if (req_tuser == MODE_ALLOC) begin
                  if (req_bytes == '0 || {1'b0, req_bytes} > (BYTES_W+1)'(HEAP_BYTES)) begin
                     state_in = ST_PUSH;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  if (req_offset[GRAN_SHIFT-1:0] != '0 || !start_ff[req_gidx]) begin
                     state_in = ST_PUSH;
                  end else begin
                     state_in = ST_LEN;
                  end
               end
            end
         end
         ST_SCAN: begin
            run_in = scan.run;
            if (scan.hit) begin
               gidx_in  = scan.first;
               state_in = ST_MARK;
            end else if (step_ff == STEP_W'(SCAN_STEPS - 1)) begin
               state_in = ST_PUSH;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_MARK: begin
            free_in          = free_ff & ~range_mask(gidx_ff, need_ff);
            start_in[gidx_ff] = 1'b1;
            res_ok_in        = 1'b1;
            res_offset_in    = OFFSET_W'({gidx_ff, GRAN_SHIFT'(0)});
            res_bytes_in     = SIZE_W'({need_ff, GRAN_SHIFT'(0)});
            state_in         = ST_PUSH;
         end
         ST_LEN: begin
            // length entry read was issued when the item was accepted
            free_in          = free_ff | range_mask(gidx_ff, mem_rd_data);
            start_in[gidx_ff] = 1'b0;
            res_ok_in        = 1'b1;
            res_bytes_in     = SIZE_W'({mem_rd_data, GRAN_SHIFT'(0)});
            state_in         = ST_PUSH;
         end
         ST_PUSH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_ff      <= '1;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      run_ff        <= run_in;
      need_ff       <= need_in;
      gidx_ff       <= gidx_in;
      res_ok_ff     <= res_ok_in;
      res_offset_ff <= res_offset_in;
      res_bytes_ff  <= res_bytes_in;
      if (rsp_load) begin
         rsp_ok_ff     <= res_ok_ff;
         rsp_offset_ff <= res_offset_ff;
         rsp_bytes_ff  <= res_bytes_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {3'b000, rsp_bytes_ff, rsp_offset_ff};

endmodule

>>> rtl/ffha_scan_unit.sv
// Shared first-fit scan unit: advances the free-run count over one window of
// granules and reports where the run starts once it first reaches need.
// Depends on ffha_pkg.
module ffha_scan_unit
   import ffha_pkg::*;
(
   input  logic [GLEN_W-1:0]     run_count,
   input  logic [GLEN_W-1:0]     need,
   input  logic [GIDX_W-1:0]     base,
   input  logic [SCAN_LANES-1:0] window_free,
   output scan_result_type       result
);

   logic [GLEN_W-1:0] run;
   logic              hit;
   logic [GLEN_W-1:0] first;

   always_comb begin
      run   = run_count;
      hit   = 1'b0;
      first = '0;
      for (int l = 0; l < SCAN_LANES; l++) begin
         if (!hit) begin
            run = window_free[l] ? run + GLEN_W'(1) : '0;
            if (run == need) begin
               hit   = 1'b1;
               first = {1'b0, base} + GLEN_W'(l) + GLEN_W'(1) - need;
            end
         end
      end
      result.hit   = hit;
      result.first = first[GIDX_W-1:0];
      result.run   = run;
   end

endmodule

>>> rtl/ffha_len_mem.sv
// Allocation length store: one entry per granule, one write and one
// registered read port. Depends on ffha_pkg.
module ffha_len_mem
   import ffha_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [GIDX_W-1:0] wr_addr,
   input  logic [GLEN_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [GIDX_W-1:0] rd_addr,
   output logic [GLEN_W-1:0] rd_data
);

   logic [GLEN_W-1:0] mem [NUM_GRANULES];
   logic [GLEN_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> bench/tb_first_fit_heap_allocator_top.sv
// Self-checking bench for first_fit_heap_allocator_top: directed corner items, then random
// allocate/free traffic checked against a free-map predictor held in a scoreboard class.
// Depends on ffha_pkg and the block's RTL.
module tb_first_fit_heap_allocator_top
   import ffha_pkg::*;
();

   localparam int IDLE_LIMIT    = 5000;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 1680;
   localparam int PAUSE_AT      = 500;
   localparam int HOLD_AT       = 900;
   localparam int DRAIN_CYCLES  = 40;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      logic              ok;
      logic [OFFSET_W-1:0] offset;
      logic [SIZE_W-1:0]   size;
   } grant_type;

   // free-map model of the heap plus the queue of grants still owed by the block
   class grant_scoreboard;
      bit                 granule_free [NUM_GRANULES];
      bit [GLEN_W-1:0]    alloc_len    [NUM_GRANULES];
      bit                 alloc_start  [NUM_GRANULES];
      grant_type          owed [$];
      int                 errors;
      int                 checked;
      int                 alloc_ok;
      int                 alloc_refused;
      int                 free_ok;
      int                 free_rejected;

      function new();
         foreach (granule_free[i]) begin
            granule_free[i] = 1'b1;
            alloc_len[i]    = '0;
            alloc_start[i]  = 1'b0;
         end
         errors = 0;
         checked = 0;
         alloc_ok = 0;
         alloc_refused = 0;
         free_ok = 0;
         free_rejected = 0;
      endfunction

      function void note_request(logic mode, logic [BYTES_W-1:0] nbytes,
                                 logic [OFFSET_W-1:0] offset);
         grant_type g;
         int need;
         int run;
         int first;
         int gi;
         g = '{ok: 1'b0, offset: '0, size: '0};
         if (mode == MODE_ALLOC) begin
            if (nbytes != 0 && int'(nbytes) <= HEAP_BYTES) begin
               need = (int'(nbytes) + GRANULE_BYTES - 1) / GRANULE_BYTES;
               run  = 0;
               for (int i = 0; i < NUM_GRANULES; i++) begin
                  run = granule_free[i] ? run + 1 : 0;
                  if (run == need && !g.ok) begin
                     first = i + 1 - need;
                     for (int k = first; k <= i; k++) granule_free[k] = 1'b0;
                     alloc_start[first] = 1'b1;
                     alloc_len[first]   = GLEN_W'(need);
                     g.ok     = 1'b1;
                     g.offset = OFFSET_W'(first * GRANULE_BYTES);
                     g.size   = SIZE_W'(need * GRANULE_BYTES);
                  end
               end
            end
            if (g.ok) alloc_ok++; else alloc_refused++;
         end else begin
            gi = int'(offset) / GRANULE_BYTES;
            if (int'(offset) % GRANULE_BYTES == 0 && gi < NUM_GRANULES && alloc_start[gi]) begin
               for (int k = 0; k < int'(alloc_len[gi]) && gi + k < NUM_GRANULES; k++)
                  granule_free[gi + k] = 1'b1;
               alloc_start[gi] = 1'b0;
               g.ok   = 1'b1;
               g.size = SIZE_W'(int'(alloc_len[gi]) * GRANULE_BYTES);
            end
            if (g.ok) free_ok++; else free_rejected++;
         end
         owed.push_back(g);
      endfunction

      function void check_response(logic ok, logic [OFFSET_W-1:0] offset,
                                   logic [SIZE_W-1:0] size);
         grant_type g;
         checked++;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("response %0d with nothing outstanding: ok=%0d off=%0d bytes=%0d",
                        checked, ok, offset, size);
         end else begin
            g = owed.pop_front();
            if (ok !== g.ok || offset !== g.offset || size !== g.size) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display({"response %0d: expected ok=%0d off=%0d bytes=%0d, ",
                            "got ok=%0d off=%0d bytes=%0d"},
                           checked, g.ok, g.offset, g.size, ok, offset, size);
            end
         end
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [15:0] request_bytes, [25:16] release_offset, rest zero
   logic        req_tuser  = 1'b0; // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [9:0] grant_offset, [20:10] grant_bytes, rest zero
   logic        rsp_tuser;         // [0] ok

   grant_scoreboard sb = new();
   int items_sent = 0;
   int idle_cycles = 0;
   bit hold_done = 1'b0;

   first_fit_heap_allocator_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_request(input logic mode, input logic [BYTES_W-1:0] nbytes,
                               input logic [OFFSET_W-1:0] offset);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {6'b0, offset, nbytes};
      do @(posedge clock); while (!req_tready);
      sb.note_request(mode, nbytes, offset);
      items_sent++;
   endtask

   // response side: ready runs, random stalls, and one long hold-off
   initial begin
      int n;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (!hold_done && items_sent >= HOLD_AT) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
      end
   end

   // response check and watchdog
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tuser, rsp_tdata[OFFSET_W-1:0],
                              rsp_tdata[OFFSET_W +: SIZE_W]);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("no handshake for %0d cycles, %0d items outstanding",
                     IDLE_LIMIT, sb.owed.size());
            $display("== FAIL ==");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      int r;
      int nlive;
      int pick;
      logic [OFFSET_W-1:0] live_offset;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner cases: bad counts, rounding, first fit into a hole, full heap,
      // misaligned / unknown / double frees, coalescing back to one run
      send_request(MODE_ALLOC,   16'd0,     10'd0);
      send_request(MODE_ALLOC,   16'hFFFF,  10'd0);
      send_request(MODE_ALLOC,   16'd1025,  10'd0);
      send_request(MODE_ALLOC,   16'd1,     10'd0);
      send_request(MODE_ALLOC,   16'd16,    10'd0);
      send_request(MODE_ALLOC,   16'd17,    10'd0);
      send_request(MODE_RELEASE, 16'd0,     10'h3FF);
      send_request(MODE_RELEASE, 16'd0,     10'd8);
      send_request(MODE_RELEASE, 16'd0,     10'd16);
      send_request(MODE_RELEASE, 16'd0,     10'd16);
      send_request(MODE_RELEASE, 16'd0,     10'd992);
      send_request(MODE_ALLOC,   16'd16,    10'd0);
      send_request(MODE_ALLOC,   16'd1024,  10'd0);
      send_request(MODE_RELEASE, 16'd0,     10'd16);
      send_request(MODE_RELEASE, 16'd0,     10'd0);
      send_request(MODE_RELEASE, 16'd0,     10'd32);
      send_request(MODE_ALLOC,   16'd1024,  10'd0);
      send_request(MODE_ALLOC,   16'd1,     10'd0);
      send_request(MODE_RELEASE, 16'd0,     10'd0);
      send_request(MODE_ALLOC,   16'd960,   10'd0);
      send_request(MODE_ALLOC,   16'd64,    10'd0);
      send_request(MODE_RELEASE, 16'd0,     10'd960);
      send_request(MODE_RELEASE, 16'd0,     10'd0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == PAUSE_AT) begin
            // stop offering so the last item is not taken twice
            req_tvalid <= 1'b0;
            do @(posedge clock); while (sb.owed.size() != 0);
         end
         nlive = 0;
         foreach (sb.alloc_start[g]) if (sb.alloc_start[g]) nlive++;
         r = $urandom_range(0, 99);
         if (r >= 50 && r < 85 && nlive > 0) begin
            // free a live allocation chosen at random
            pick = $urandom_range(0, nlive - 1);
            live_offset = '0;
            foreach (sb.alloc_start[g]) begin
               if (sb.alloc_start[g]) begin
                  if (pick == 0) live_offset = OFFSET_W'(g * GRANULE_BYTES);
                  pick--;
               end
            end
            send_request(MODE_RELEASE, 16'($urandom), live_offset);
         end else if (r < 85) begin
            r = $urandom_range(0, 99);
            if (r < 80)
               send_request(MODE_ALLOC, 16'($urandom_range(1, 160)), 10'($urandom));
            else if (r < 95)
               send_request(MODE_ALLOC, 16'($urandom_range(1, 512)), 10'($urandom));
            else
               send_request(MODE_ALLOC, 16'($urandom_range(1, HEAP_BYTES)), 10'($urandom));
         end else if (r < 90) begin
            send_request(MODE_ALLOC, 16'($urandom), 10'($urandom));
         end else if (r < 95) begin
            send_request(MODE_RELEASE, 16'($urandom), 10'($urandom));
         end else begin
            // aligned offset, usually not live: stale and double frees
            send_request(MODE_RELEASE, 16'($urandom),
                         OFFSET_W'($urandom_range(0, NUM_GRANULES - 1) * GRANULE_BYTES));
         end
      end
      req_tvalid <= 1'b0;

      while (sb.owed.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items: %0d allocations granted, %0d refused, %0d frees done, %0d rejected",
               items_sent, sb.alloc_ok, sb.alloc_refused, sb.free_ok, sb.free_rejected);
      $display("%0d responses checked, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
